// ===== rtl/pa_pkg.sv =====
// Shared types and constants for the page allocator.
`default_nettype none

package pa_pkg;

    // Geometry
    localparam int NUM_PAGES  = 4096;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_AW    = $clog2(NUM_PAGES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    // Field widths
    localparam int CNT_W  = 13;
    localparam int ADDR_W = 32;
    localparam int RC_W   = 32;
    localparam int FUNC_W = 3;
    localparam int PNUM_W = ADDR_W - PAGE_SHIFT;
    localparam int WORD_W = RC_W + 1;

    // Stream payload widths
    localparam int IN_FIELDS_W  = ADDR_W + CNT_W + ADDR_W;
    localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + ADDR_W + RC_W + CNT_W + CNT_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [RC_W-1:0] RC_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC = 3'd0,
        FN_FREE  = 3'd1,
        FN_MARK  = 3'd2,
        FN_INC   = 3'd3,
        FN_DEC   = 3'd4,
        FN_GET   = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_RD,
        ST_WR,
        ST_DONE
    } state_t;

    // Result of one page read-modify-write
    typedef struct packed {
        logic            used;
        logic [RC_W-1:0] count;
        logic [RC_W-1:0] rc;
        logic            claim;
        logic            drop;
    } upd_t;

endpackage

`default_nettype wire

// ===== rtl/pa_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module pa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/pa_page_unit.sv =====
// Per-page update unit: new used bit and reference count for one page.
`default_nettype none

module pa_page_unit
    import pa_pkg::*;
(
    input  wire func_t              func,
    input  wire logic [WORD_W-1:0] word,
    output upd_t                    upd
);

    logic            used;
    logic [RC_W-1:0] count;
    logic [RC_W-1:0] dec_count;

    assign used      = word[WORD_W-1];
    assign count     = word[RC_W-1:0];
    assign dec_count = (count != '0) ? count - RC_W'(1) : '0;

    // Compute the page's new state for the operation
    always_comb
    begin
        upd.used  = used;
        upd.count = count;
        upd.rc    = count;
        upd.claim = 1'b0;
        upd.drop  = 1'b0;
        case (func)
            FN_FREE, FN_DEC:
            begin
                if (!used)
                begin
                    upd.count = '0;
                    upd.rc    = '0;
                end
                else if (dec_count != '0)
                begin
                    upd.count = dec_count;
                    upd.rc    = dec_count;
                end
                else
                begin
                    upd.used  = 1'b0;
                    upd.count = '0;
                    upd.rc    = '0;
                    upd.drop  = 1'b1;
                end
            end
            FN_MARK, FN_INC:
            begin
                if (!used)
                begin
                    upd.used  = 1'b1;
                    upd.count = RC_W'(1);
                    upd.rc    = RC_W'(1);
                    upd.claim = 1'b1;
                end
                else if (count == '0)
                begin
                    upd.count = RC_W'(1);
                    upd.rc    = RC_W'(1);
                end
                else if (func == FN_INC && count != RC_MAX)
                begin
                    upd.count = count + RC_W'(1);
                    upd.rc    = count + RC_W'(1);
                end
            end
            default:
            begin
                upd.rc = count;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/page_allocator_with_refcounts.sv =====
// Page allocator top level: sequencer, page store and result register.
// Flow: an item is accepted in idle; alloc scans the store for a free run, then fills any run found;
// free and mark read then write each page in range; ref ops read then write one page;
// the result register is then loaded. One item is in flight at a time.
// Reset and every active_pages write start a store-clearing pass (one page per cycle
// through the single write port) during which no item is taken.
`default_nettype none

module page_allocator_with_refcounts
    import pa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [CNT_W-1:0]    cfg_wr_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [IN_W-1:0]     s_tdata,  // address, page_count, byte_length, zero pad
    input  wire logic [FUNC_W-1:0]   s_tuser,  // func
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [OUT_W-1:0]    m_tdata   // ok, result_address, ref_count,
                                               // free_pages, used_total, zero pad
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    active_reg, active_next;
    logic [CNT_W-1:0]    used_cnt_reg, used_cnt_next;
    func_t               func_reg, func_next;
    logic [PAGE_AW-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]    end_reg, end_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic                pend_reg, pend_next;
    logic [PAGE_AW-1:0]  proc_reg, proc_next;
    logic [CNT_W-1:0]    run_reg, run_next;
    logic [PAGE_AW-1:0]  start_reg, start_next;
    logic [PAGE_AW-1:0]  clr_reg, clr_next;
    logic                ok_reg, ok_next;
    logic [ADDR_W-1:0]   res_reg, res_next;
    logic [RC_W-1:0]     rc_reg, rc_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]    m_tdata_reg, m_tdata_next;

    logic [CNT_W-1:0]    act, cfg_act, free_pages;
    logic [ADDR_W-1:0]   in_addr, in_blen;
    logic [CNT_W-1:0]    in_cnt;
    func_t               in_func;
    logic [PNUM_W-1:0]   in_page;
    logic                in_range;
    logic [CNT_W:0]      free_sum;
    logic [CNT_W-1:0]    free_end, mark_end, single_end;
    logic [ADDR_W:0]     mark_sum;
    logic [PNUM_W:0]     mark_last;
    logic                cur_last, scan_hit, out_free;
    logic [PAGE_AW-1:0]  hit_start;

    logic                ram_we;
    logic [PAGE_AW-1:0]  ram_waddr, ram_raddr;
    logic [WORD_W-1:0]   ram_wdata, ram_rdata;
    upd_t                upd;

    // Page store: used bit over the reference count
    pa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_PAGES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared page update unit
    pa_page_unit u_unit (
        .func (func_reg),
        .word (ram_rdata),
        .upd  (upd)
    );

    // Clamp page counts to the built capacity
    assign act     = (active_reg > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : active_reg;
    assign cfg_act = (cfg_wr_data > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : cfg_wr_data;
    assign free_pages = (act >= used_cnt_reg) ? act - used_cnt_reg : '0;

    // Decode the incoming item
    assign in_addr    = s_tdata[ADDR_W-1:0];
    assign in_cnt     = s_tdata[ADDR_W+CNT_W-1:ADDR_W];
    assign in_blen    = s_tdata[IN_FIELDS_W-1:ADDR_W+CNT_W];
    assign in_func    = func_t'(s_tuser);
    assign in_page    = in_addr[ADDR_W-1:PAGE_SHIFT];
    assign in_range   = in_page < PNUM_W'(act);
    assign free_sum   = {1'b0, in_page[CNT_W-1:0]} + {1'b0, in_cnt};
    assign free_end   = (free_sum > {1'b0, act}) ? act : free_sum[CNT_W-1:0];
    assign mark_sum   = {1'b0, in_addr} + {1'b0, in_blen} - (ADDR_W+1)'(1);
    assign mark_last  = mark_sum[ADDR_W:PAGE_SHIFT];
    assign mark_end   = (mark_last >= (PNUM_W+1)'(act)) ? act
                      : mark_last[CNT_W-1:0] + CNT_W'(1);
    assign single_end = CNT_W'(in_page[PAGE_AW-1:0]) + CNT_W'(1);

    // Loop and scan conditions
    assign cur_last  = (CNT_W'(cur_reg) + CNT_W'(1)) >= end_reg;
    assign scan_hit  = pend_reg && !ram_rdata[WORD_W-1]
                    && (run_reg + CNT_W'(1) == cnt_reg);
    assign hit_start = (run_reg == '0) ? proc_reg : start_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == PAGE_AW'(NUM_PAGES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DONE;
                    case (in_func)
                        FN_ALLOC:
                        begin
                            if (in_cnt != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        FN_FREE:
                        begin
                            if (in_addr != '0 && in_cnt != '0 && in_range)
                            begin
                                state_next = ST_RD;
                            end
                        end
                        FN_MARK:
                        begin
                            if (in_blen != '0 && in_range)
                            begin
                                state_next = ST_RD;
                            end
                        end
                        FN_INC, FN_DEC, FN_GET:
                        begin
                            if (in_range)
                            begin
                                state_next = ST_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = ST_FILL;
                end
                else if (!pend_reg && issue_reg >= act)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FILL:
            begin
                if (cur_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                state_next = cur_last ? ST_DONE : ST_RD;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_wr_en)
        begin
            state_next = ST_CLEAR;
        end
    end

    // Store port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_reg;
        ram_wdata = {1'b1, RC_W'(1)};
        ram_raddr = (state_reg == ST_SCAN) ? issue_reg[PAGE_AW-1:0] : cur_reg;
        s_tready  = (state_reg == ST_IDLE);
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
            end
            ST_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = {upd.used, upd.count};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        active_next   = active_reg;
        used_cnt_next = used_cnt_reg;
        func_next     = func_reg;
        cur_next      = cur_reg;
        end_next      = end_reg;
        cnt_next      = cnt_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        proc_next     = proc_reg;
        run_next      = run_reg;
        start_next    = start_reg;
        clr_next      = clr_reg;
        ok_next       = ok_reg;
        res_next      = res_reg;
        rc_next       = rc_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        // Drop the result once it is taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + PAGE_AW'(1);
            end
            ST_IDLE:
            begin
                // Latch the item and its page range
                func_next  = in_func;
                cnt_next   = in_cnt;
                cur_next   = in_page[PAGE_AW-1:0];
                issue_next = '0;
                pend_next  = 1'b0;
                run_next   = '0;
                ok_next    = 1'b0;
                res_next   = '0;
                rc_next    = '0;
                case (in_func)
                    FN_FREE:
                    begin
                        end_next = free_end;
                        ok_next  = (in_addr != '0 && in_cnt != '0 && in_range);
                    end
                    FN_MARK:
                    begin
                        end_next = mark_end;
                        ok_next  = (in_blen != '0 && in_range);
                    end
                    FN_INC, FN_DEC, FN_GET:
                    begin
                        end_next = single_end;
                        ok_next  = in_range;
                    end
                    default:
                    begin
                        end_next = end_reg;
                    end
                endcase
            end
            ST_SCAN:
            begin
                // Issue the next bitmap read
                pend_next = issue_reg < act;
                if (issue_reg < act)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                    proc_next  = issue_reg[PAGE_AW-1:0];
                end
                // Track the current free run
                if (pend_reg)
                begin
                    if (ram_rdata[WORD_W-1])
                    begin
                        run_next = '0;
                    end
                    else
                    begin
                        start_next = hit_start;
                        run_next   = run_reg + CNT_W'(1);
                    end
                end
                if (scan_hit)
                begin
                    cur_next = hit_start;
                    end_next = CNT_W'(proc_reg) + CNT_W'(1);
                    ok_next  = 1'b1;
                    res_next = ADDR_W'(hit_start) << PAGE_SHIFT;
                end
            end
            ST_FILL:
            begin
                cur_next = cur_reg + PAGE_AW'(1);
                if (cur_last)
                begin
                    used_cnt_next = used_cnt_reg + cnt_reg;
                end
            end
            ST_WR:
            begin
                cur_next = cur_reg + PAGE_AW'(1);
                if (upd.claim)
                begin
                    used_cnt_next = used_cnt_reg + CNT_W'(1);
                end
                else if (upd.drop && used_cnt_reg != '0)
                begin
                    used_cnt_next = used_cnt_reg - CNT_W'(1);
                end
                if (func_reg == FN_INC || func_reg == FN_DEC || func_reg == FN_GET)
                begin
                    rc_next = upd.rc;
                end
            end
            ST_DONE:
            begin
                // Load the output register
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({used_cnt_reg, free_pages, rc_reg,
                                            res_reg, ok_reg});
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase

        // Register write restarts the clearing pass
        if (cfg_wr_en)
        begin
            active_next   = cfg_wr_data;
            used_cnt_next = cfg_act;
            clr_next      = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            active_reg   <= CNT_W'(NUM_PAGES);
            used_cnt_reg <= CNT_W'(NUM_PAGES);
            clr_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            used_cnt_reg <= used_cnt_next;
            clr_reg      <= clr_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        cur_reg     <= cur_next;
        end_reg     <= end_next;
        cnt_reg     <= cnt_next;
        issue_reg   <= issue_next;
        proc_reg    <= proc_next;
        run_reg     <= run_next;
        start_reg   <= start_next;
        ok_reg      <= ok_next;
        res_reg     <= res_next;
        rc_reg      <= rc_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Used-page count never exceeds the built capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        used_cnt_reg <= CNT_W'(NUM_PAGES))
        else $error("used page counter above capacity");

    // No item is taken while the store is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("item accepted during clearing pass");

    // An accepted item leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !cfg_wr_en) |=> (state_reg != ST_IDLE))
        else $error("accepted item not started");

    // A result is loaded only from the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_DONE))
        else $error("result loaded outside done state");

endmodule

`default_nettype wire

// ===== tb/sv/tb_page_allocator_with_refcounts.sv =====
// Self-checking testbench for the page allocator with reference counts.
`timescale 1ns / 100ps

module tb_page_allocator_with_refcounts;
    import pa_pkg::*;

    localparam int IDLE_LIMIT = 60000;

    typedef struct {
        logic              ok;
        logic [ADDR_W-1:0] res_addr;
        logic [RC_W-1:0]   rc;
        logic [CNT_W-1:0]  free_pg;
        logic [CNT_W-1:0]  used_pg;
    } outcome_t;

    // Page store mirror, prediction of each outcome and comparison of results
    class page_ledger;
        bit              used_map [NUM_PAGES];
        logic [RC_W-1:0] refs [NUM_PAGES];
        int unsigned     used_cnt;
        int unsigned     act;
        outcome_t        awaited [$];
        int              errors;
        int              checked;

        function void restore(logic [CNT_W-1:0] pages);
            act = (pages > NUM_PAGES) ? NUM_PAGES : pages;
            for (int i = 0; i < NUM_PAGES; i++)
            begin
                used_map[i] = 1'b1;
                refs[i] = 1;
            end
            used_cnt = act;
        endfunction

        function logic [RC_W-1:0] drop_page(int unsigned pg);
            logic [RC_W-1:0] c;
            if (!used_map[pg])
            begin
                refs[pg] = 0;
                return 0;
            end
            c = refs[pg];
            if (c > 0)
            begin
                c = c - 1;
                refs[pg] = c;
            end
            if (c > 0)
                return c;
            used_map[pg] = 1'b0;
            if (used_cnt > 0)
                used_cnt--;
            refs[pg] = 0;
            return 0;
        endfunction

        function void claim_page(int unsigned pg);
            if (!used_map[pg])
            begin
                used_map[pg] = 1'b1;
                used_cnt++;
                refs[pg] = 1;
            end
            else if (refs[pg] == 0)
                refs[pg] = 1;
        endfunction

        // Apply one accepted transfer to the mirror and queue its outcome
        function void note_item(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] addr,
                                logic [CNT_W-1:0] cnt, logic [ADDR_W-1:0] blen);
            outcome_t        o;
            longint unsigned pg;
            longint unsigned last;
            int unsigned     run;
            int unsigned     start;
            o = '{default: '0};
            pg = longint'(addr) / PAGE_BYTES;
            run = 0;
            start = 0;
            case (fn)
                FN_ALLOC:
                begin
                    if (cnt != 0)
                    begin
                        for (int unsigned i = 0; i < act; i++)
                        begin
                            if (used_map[i])
                            begin
                                run = 0;
                                continue;
                            end
                            if (run == 0)
                                start = i;
                            run++;
                            if (run == cnt)
                            begin
                                for (int unsigned j = start; j < start + cnt; j++)
                                begin
                                    used_map[j] = 1'b1;
                                    refs[j] = 1;
                                end
                                used_cnt += cnt;
                                o.ok = 1'b1;
                                o.res_addr = start * PAGE_BYTES;
                                break;
                            end
                        end
                    end
                end
                FN_FREE:
                begin
                    if (addr != 0 && cnt != 0 && pg < act)
                    begin
                        o.ok = 1'b1;
                        for (int unsigned i = 0; i < cnt; i++)
                            if (pg + i < act)
                                void'(drop_page(int'(pg + i)));
                    end
                end
                FN_MARK:
                begin
                    if (blen != 0 && pg < act)
                    begin
                        last = (longint'(addr) + longint'(blen) - 1) / PAGE_BYTES;
                        if (last >= act)
                            last = act - 1;
                        o.ok = 1'b1;
                        for (longint unsigned p = pg; p <= last; p++)
                            claim_page(int'(p));
                    end
                end
                FN_INC:
                begin
                    if (pg < act)
                    begin
                        o.ok = 1'b1;
                        if (!used_map[pg] || refs[pg] == 0)
                            claim_page(int'(pg));
                        else if (refs[pg] != RC_MAX)
                            refs[pg] = refs[pg] + 1;
                        o.rc = refs[pg];
                    end
                end
                FN_DEC:
                begin
                    if (pg < act)
                    begin
                        o.ok = 1'b1;
                        o.rc = drop_page(int'(pg));
                    end
                end
                FN_GET:
                begin
                    if (pg < act)
                    begin
                        o.ok = 1'b1;
                        o.rc = refs[pg];
                    end
                end
                default: ;
            endcase
            o.free_pg = CNT_W'((act >= used_cnt) ? act - used_cnt : 0);
            o.used_pg = CNT_W'(used_cnt);
            awaited.push_back(o);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one result transfer with the oldest outcome
        task check_result(logic [OUT_W-1:0] d);
            outcome_t e;
            if (awaited.size() == 0)
            begin
                report("result with no outcome pending");
                return;
            end
            e = awaited.pop_front();
            checked++;
            if (d[0] !== e.ok)
                report($sformatf("item %0d ok %0b exp %0b", checked, d[0], e.ok));
            if (d[32:1] !== e.res_addr)
                report($sformatf("item %0d address %h exp %h", checked, d[32:1], e.res_addr));
            if (d[64:33] !== e.rc)
                report($sformatf("item %0d ref_count %0d exp %0d", checked, d[64:33], e.rc));
            if (d[77:65] !== e.free_pg)
                report($sformatf("item %0d free %0d exp %0d", checked, d[77:65], e.free_pg));
            if (d[90:78] !== e.used_pg)
                report($sformatf("item %0d used %0d exp %0d", checked, d[90:78], e.used_pg));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic [FUNC_W-1:0]   s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    page_ledger ledger = new();
    bit         no_idle = 1'b0;
    bit         rx_hold = 1'b0;
    int         idle_cycles = 0;
    int         phases_run = 0;

    page_allocator_with_refcounts dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #5 clk = ~clk;

    // Watchdog: end the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                rx_hold = 1'b0;
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 17);
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            ledger.check_result(m_tdata);
            // Hold off until the next transfer is chosen
            m_tready <= 1'b0;
        end
    end

    // Offer one item and hold it until transferred; called right after posedge clk
    task automatic send_item(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] addr,
                             logic [CNT_W-1:0] cnt, logic [ADDR_W-1:0] blen);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {3'b000, blen, cnt, addr};
        do @(posedge clk); while (!s_tready);
        ledger.note_item(fn, addr, cnt, blen);
    endtask

    // Drain results, then write active_pages while the block is idle
    task automatic write_pages(logic [CNT_W-1:0] pages);
        s_tvalid <= 1'b0;
        wait (ledger.awaited.size() == 0);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= pages;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        ledger.restore(pages);
        phases_run++;
    endtask

    // One random item, mostly well-formed for the current page count
    task automatic random_item();
        logic [FUNC_W-1:0] fn;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  cnt;
        logic [ADDR_W-1:0] blen;
        int unsigned       r;
        r = $urandom_range(0, 99);
        if (r < 2)
            fn = FUNC_W'($urandom_range(6, 7));
        else if (r < 30)
            fn = FN_ALLOC;
        else if (r < 55)
            fn = FN_FREE;
        else if (r < 65)
            fn = FN_MARK;
        else
            fn = FUNC_W'($urandom_range(FN_INC, FN_GET));
        if ($urandom_range(0, 9) == 0)
            addr = $urandom;
        else
            addr = $urandom_range(0, ledger.act) * PAGE_BYTES
                   + ($urandom_range(0, 3) == 0 ? $urandom_range(0, PAGE_BYTES - 1) : 0);
        r = $urandom_range(0, 19);
        if (r == 0)
            cnt = CNT_W'($urandom);
        else if (r < 3)
            cnt = CNT_W'($urandom_range(0, 15));
        else
            cnt = CNT_W'($urandom_range(1, 4));
        r = $urandom_range(0, 19);
        if (r == 0)
            blen = $urandom;
        else if (r == 1)
            blen = 0;
        else
            blen = $urandom_range(1, 3 * PAGE_BYTES);
        send_item(fn, addr, cnt, blen);
    endtask

    task automatic run_phase(int items, bit pressure);
        // Release every page but page zero so allocations can succeed
        send_item(FN_FREE, PAGE_BYTES, CNT_W'(NUM_PAGES), 0);
        for (int n = 0; n < items; n++)
        begin
            no_idle = (n % 100) >= 70;
            if (pressure && n == items / 3)
                rx_hold = 1'b1;
            if (pressure && n == (2 * items) / 3)
            begin
                s_tvalid <= 1'b0;
                wait (ledger.awaited.size() == 0);
                @(posedge clk);
            end
            random_item();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        logic [CNT_W-1:0] page_set [7] = '{64, 1, 0, 4096, 8191, 300, 13};
        ledger.restore(NUM_PAGES);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: null and zero-size requests, page zero, out of range, unknown codes
        send_item(FN_FREE, 0, 5, 0);
        send_item(FN_FREE, PAGE_BYTES, 0, 0);
        send_item(FN_FREE, NUM_PAGES * PAGE_BYTES, 3, 0);
        send_item(FN_FREE, PAGE_BYTES, 13'h1FFF, 0);
        send_item(FN_DEC, 0, 0, 0);
        send_item(FN_ALLOC, 0, 1, 0);
        send_item(FN_ALLOC, 0, 0, 0);
        send_item(FN_ALLOC, 0, 13'h1FFF, 0);
        send_item(FN_ALLOC, 0, CNT_W'(NUM_PAGES), 0);
        send_item(FN_GET, 32'hFFFF_FFFF, 0, 0);
        send_item(FN_DEC, 32'hFFFF_FFFF, 0, 0);
        send_item(FN_INC, 32'hFFFF_FFFF, 0, 0);
        send_item(FN_DEC, 10 * PAGE_BYTES, 0, 0);
        send_item(FN_INC, 10 * PAGE_BYTES + 7, 0, 0);
        send_item(FN_INC, 10 * PAGE_BYTES, 0, 0);
        send_item(FN_GET, 10 * PAGE_BYTES, 0, 0);
        send_item(FN_MARK, 20 * PAGE_BYTES, 0, 0);
        send_item(FN_MARK, 32'hFFFF_F000, 0, 5);
        send_item(FN_MARK, 20 * PAGE_BYTES + 1, 0, 2 * PAGE_BYTES);
        send_item(FN_MARK, (NUM_PAGES - 1) * PAGE_BYTES + 5, 0, 32'hFFFF_FFFF);
        send_item(FUNC_W'(6), 32'hFFFF_FFFF, 13'h1FFF, 32'hFFFF_FFFF);
        send_item(FUNC_W'(7), 0, 0, 0);
        send_item(FN_FREE, 100 * PAGE_BYTES, 200, 0);
        send_item(FN_ALLOC, 0, 150, 0);
        send_item(FN_FREE, PAGE_BYTES, 13'h1FFF, 0);
        send_item(FN_ALLOC, 0, 13'd4000, 0);

        run_phase(60, 1'b0);
        foreach (page_set[k])
        begin
            write_pages(page_set[k]);
            run_phase((page_set[k] >= NUM_PAGES) ? 80 : 300, k == 0);
        end
        s_tvalid <= 1'b0;

        // Drain and let the block settle
        wait (ledger.awaited.size() == 0);
        repeat (50) @(posedge clk);
        if (m_tvalid)
            ledger.report("result after the last outcome");
        $display("Checked %0d results over %0d register settings,", ledger.checked,
                 phases_run + 1);
        $display("including empty, single-page, full and oversized page counts.");
        if (ledger.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
